// ===== rtl/rfs_pkg.sv =====
// Package: shared widths, codes and reset values for the reliable frame sender.
`timescale 1ns / 1ps

package rfs_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int TIME_W    = 32;
    localparam int OPC_W     = 8;
    localparam int SES_W     = 32;
    localparam int SEQ_W     = 16;
    localparam int FLEN_W    = 8;
    localparam int LEN_W     = 5;
    localparam int PAY_W     = 64;
    localparam int RETRY_W   = 16;
    localparam int ATT_W     = 3;
    localparam int STAT_W    = 3;
    localparam int RES_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DATA_W = 224;
    localparam int OUT_DATA_W = 200;

    // Defaults for top-level parameters
    localparam int DEF_ACK_OPCODE  = 128;
    localparam int DEF_MAX_PAYLOAD = 16;

    // Command codes (s_tuser)
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;

    // Result codes
    localparam logic [RES_W-1:0] RES_NONE   = 2'd0;
    localparam logic [RES_W-1:0] RES_OK     = 2'd1;
    localparam logic [RES_W-1:0] RES_GAVEUP = 2'd2;

    // Status codes beyond the peer range 0..3
    localparam logic [STAT_W-1:0] ST_PENDING = 3'd4;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd5;
    localparam logic [OPC_W-1:0]  PEER_STATUS_MAX = 8'd3;
    localparam logic [FLEN_W-1:0] ACK_FRAME_LEN   = 8'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS = 2'd2;

    // Reset values
    localparam logic [RETRY_W-1:0] RST_RETRY    = 16'd500;
    localparam logic [ATT_W-1:0]   RST_ATTEMPTS = 3'd4;
    localparam logic [SEQ_W-1:0]   RST_NEXT_SEQ = 16'd1;

endpackage

// ===== rtl/reliable_frame_sender.sv =====
// Top level: stop-and-wait frame sender with timed retransmission.
`timescale 1ns / 1ps

// Stop-and-wait sender. Each slave transaction is one event selected by s_tuser:
// begin (latch and number a frame), poll (send, resend after retry_interval, or
// give up after max_attempts sends) or a received acknowledgement (ends the
// exchange and records the peer status). Every event yields exactly one master
// transaction carrying the sent frame (all zero when nothing goes out), the
// status and the busy flag. Throughput is one transaction per clock while m_tready
// is high. Each event passes the input register, the event logic and the result
// register; s_tready follows m_tready combinationally through that two-stage
// pipeline, so a stalled output holds at most two events in flight. The user must
// write configuration via cfg_wr_en/cfg_addr/cfg_wdata only while idle; not enforced.
module reliable_frame_sender
    import rfs_pkg::*;
#(
    parameter int ACK_OPCODE  = DEF_ACK_OPCODE,  // 0..255
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD  // 1..16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DAT_W-1:0]  cfg_wdata,
    // event input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata, low bit up: now[31:0], frame_opcode[39:32], frame_session[71:40],
    // frame_sequence[87:72], frame_length[95:88], payload_low[159:96],
    // payload_high[223:160]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: command[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata, low bit up: result_code[1:0], out_opcode[9:2], out_session[41:10],
    // out_sequence[57:42], out_length[62:58], out_payload_low[126:63],
    // out_payload_high[190:127], send_status[193:191], busy_flag[194], zeros
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic [OPC_W-1:0]  ACK_OPC  = OPC_W'(ACK_OPCODE);
    localparam logic [FLEN_W-1:0] MAX_FLEN = FLEN_W'(MAX_PAYLOAD);
    localparam int NBYTES = 2 * PAY_W / 8;

    // ---------------- configuration registers ----------------
    logic [SES_W-1:0]   session_id_reg;
    logic [RETRY_W-1:0] retry_interval_reg;
    logic [ATT_W-1:0]   max_attempts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_id_reg     <= '0;
            retry_interval_reg <= RST_RETRY;
            max_attempts_reg   <= RST_ATTEMPTS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_SESSION:  session_id_reg     <= cfg_wdata;
                CFG_RETRY:    retry_interval_reg <= cfg_wdata[RETRY_W-1:0];
                CFG_ATTEMPTS: max_attempts_reg   <= cfg_wdata[ATT_W-1:0];
                default:      ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;   // result register can take a new result
    logic step;      // event in the input register is processed this cycle
    logic s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign step     = in_valid_reg && advance;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- input register ----------------
    logic [CMD_W-1:0]  cmd_reg;
    logic [TIME_W-1:0] now_reg;
    logic [OPC_W-1:0]  fopc_reg;
    logic [SES_W-1:0]  fses_reg;
    logic [SEQ_W-1:0]  fseq_reg;
    logic [FLEN_W-1:0] flen_reg;
    logic [PAY_W-1:0]  plo_reg;
    logic [PAY_W-1:0]  phi_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg  <= s_tuser;
            now_reg  <= s_tdata[31:0];
            fopc_reg <= s_tdata[39:32];
            fses_reg <= s_tdata[71:40];
            fseq_reg <= s_tdata[87:72];
            flen_reg <= s_tdata[95:88];
            plo_reg  <= s_tdata[159:96];
            phi_reg  <= s_tdata[223:160];
        end
    end

    // ---------------- sender state ----------------
    logic               busy_reg, busy_next;
    logic [ATT_W-1:0]   attempt_reg, attempt_next;
    logic [TIME_W-1:0]  last_send_reg, last_send_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [OPC_W-1:0]   held_opc_reg, held_opc_next;
    logic [LEN_W-1:0]   held_len_reg, held_len_next;
    logic [SEQ_W-1:0]   held_seq_reg, held_seq_next;
    logic [2*PAY_W-1:0] held_pay_reg, held_pay_next;
    logic [STAT_W-1:0]  status_reg, status_next;

    // event decode
    logic [2*PAY_W-1:0] pay_in;
    logic [2*PAY_W-1:0] pay_masked;
    logic [TIME_W-1:0]  elapsed;
    logic               begin_ok, poll_due, ack_ok, sent;
    logic [RES_W-1:0]   res_code;

    assign pay_in = {phi_reg, plo_reg};

    // bytes at or beyond the frame length are cleared
    always_comb
    begin
        for (int k = 0; k < NBYTES; k++)
        begin
            pay_masked[8*k +: 8] = (flen_reg > FLEN_W'(k)) ? pay_in[8*k +: 8] : 8'd0;
        end
    end

    assign elapsed  = now_reg - last_send_reg;
    assign begin_ok = !busy_reg && (session_id_reg != '0) && (flen_reg <= MAX_FLEN)
                      && (fopc_reg != ACK_OPC);
    assign poll_due = busy_reg && !((attempt_reg != '0) &&
                      (elapsed < {{(TIME_W-RETRY_W){1'b0}}, retry_interval_reg}));
    assign ack_ok   = busy_reg && (attempt_reg != '0) && (fopc_reg == ACK_OPC)
                      && (fses_reg == session_id_reg) && (fseq_reg == held_seq_reg)
                      && (flen_reg == ACK_FRAME_LEN) && (plo_reg[7:0] == held_opc_reg)
                      && (plo_reg[15:8] <= PEER_STATUS_MAX);

    always_comb
    begin
        busy_next      = busy_reg;
        attempt_next   = attempt_reg;
        last_send_next = last_send_reg;
        next_seq_next  = next_seq_reg;
        held_opc_next  = held_opc_reg;
        held_len_next  = held_len_reg;
        held_seq_next  = held_seq_reg;
        held_pay_next  = held_pay_reg;
        status_next    = status_reg;
        res_code       = RES_NONE;
        sent           = 1'b0;
        unique case (cmd_reg)
            CMD_BEGIN:
            begin
                if (begin_ok)
                begin
                    held_opc_next = fopc_reg;
                    held_len_next = flen_reg[LEN_W-1:0];
                    held_seq_next = next_seq_reg;
                    next_seq_next = next_seq_reg + SEQ_W'(1);
                    held_pay_next = pay_masked;
                    busy_next     = 1'b1;
                    attempt_next  = '0;
                    status_next   = ST_PENDING;
                    res_code      = RES_OK;
                end
            end
            CMD_POLL:
            begin
                if (poll_due)
                begin
                    if (attempt_reg >= max_attempts_reg)
                    begin
                        busy_next   = 1'b0;
                        status_next = ST_TIMEOUT;
                        res_code    = RES_GAVEUP;
                    end
                    else
                    begin
                        attempt_next   = attempt_reg + ATT_W'(1);
                        last_send_next = now_reg;
                        sent           = 1'b1;
                        res_code       = RES_OK;
                    end
                end
            end
            CMD_ACK:
            begin
                if (ack_ok)
                begin
                    busy_next   = 1'b0;
                    status_next = plo_reg[8 +: STAT_W];
                    res_code    = RES_OK;
                end
            end
            default: ;  // unknown command: no change, nothing sent
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            attempt_reg   <= '0;
            last_send_reg <= '0;
            next_seq_reg  <= RST_NEXT_SEQ;
            held_opc_reg  <= '0;
            held_len_reg  <= '0;
            held_seq_reg  <= '0;
            held_pay_reg  <= '0;
            status_reg    <= '0;
        end
        else if (step)
        begin
            busy_reg      <= busy_next;
            attempt_reg   <= attempt_next;
            last_send_reg <= last_send_next;
            next_seq_reg  <= next_seq_next;
            held_opc_reg  <= held_opc_next;
            held_len_reg  <= held_len_next;
            held_seq_reg  <= held_seq_next;
            held_pay_reg  <= held_pay_next;
            status_reg    <= status_next;
        end
    end

    // ---------------- result register ----------------
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    always_comb
    begin
        out_data_next          = '0;
        out_data_next[1:0]     = res_code;
        if (sent)
        begin
            out_data_next[9:2]     = held_opc_reg;
            out_data_next[41:10]   = session_id_reg;
            out_data_next[57:42]   = held_seq_reg;
            out_data_next[62:58]   = held_len_reg;
            out_data_next[190:63]  = held_pay_reg;
        end
        out_data_next[193:191] = status_next;
        out_data_next[194]     = busy_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // busy and the pending status always move together
    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (status_reg == ST_PENDING))
        else $error("busy and pending status disagree");

    // a nonzero frame length on the output only comes with a send
    a_frame_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[62:58] != '0)) |-> (m_tdata[1:0] == RES_OK))
        else $error("frame fields set without a send");

    // sequence number advances only on an accepted begin
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_seq_reg != $past(next_seq_reg)) |->
            $past(step && (cmd_reg == CMD_BEGIN) && begin_ok))
        else $error("sequence number moved without a begin");

    // a send never happens while idle
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && sent) |=> busy_reg)
        else $error("frame sent with no exchange in progress");
`endif

endmodule
